// ----- src/oktv_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered key-value table package
// Opcodes, status codes and sequencer states shared by the table and checker.
// ----------------------------------------------------------------------------
package oktv_pkg;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_ACCESS = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned TOTAL_W = 7;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

endpackage

// ----- src/ordered_key_value_table_unit.sv -----
// ----------------------------------------------------------------------------
// Ordered key-value table
// Packed insertion-ordered table in one single-port-read memory, searched
// linearly and compacted on remove by a small sequencer.
//
//   channel  dir  tdata                          tuser
//   s_axis   in   [31:0] key, [63:32] value      [2:0] opcode
//   m_axis   out  [31:0] read_value,             [0] found, [2:1] status
//                 [38:32] entry_total
//
// A lookup reads the N live entries in order until a hit, then registers the result.
// A remove that hits index i then moves the entries above it down by one.
// Clear, and remove on an empty table, go straight to the result without a search.
// Reset clears the entry count and control state; the memory is not swept.
// An input is taken only while idle; a stalled result holds in the output
// register while the next request already runs.
// ----------------------------------------------------------------------------
module ordered_key_value_table_unit #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // key[31:0], value[63:32]
  input  logic [2:0]  s_axis_tuser_i,   // opcode[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // read_value[31:0], entry_total[38:32], zero[39]
  output logic [2:0]  m_axis_tuser_o    // found[0], status[2:1]
);
  import oktv_pkg::*;

  localparam int unsigned KEY_BITS = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
  localparam int unsigned VAL_BITS = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int unsigned ENT_W    = KEY_BITS + VAL_BITS;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  logic [ENT_W-1:0] mem_q [CAPACITY];
  logic [ENT_W-1:0] rd_q;
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [ENT_W-1:0] wd;

  state_e              state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [VAL_BITS-1:0] value_q, value_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    addr_q, addr_d;
  logic                cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]    dst_q, dst_d;
  logic                sv_q, sv_d;
  logic [VAL_BITS-1:0] rv_q, rv_d;
  logic                found_q, found_d;
  logic [1:0]          status_q, status_d;

  logic                mv_q, mv_d;
  logic [VAL_BITS-1:0] out_rv_q, out_rv_d;
  logic                out_found_q, out_found_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;

  logic hit;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {1'b0, out_total_q, FIELD_W'(out_rv_q)};
  assign m_axis_tuser_o  = {out_status_q, out_found_q};

  assign hit = cmp_v_q && (rd_q[ENT_W-1:VAL_BITS] == key_q);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    value_d      = value_q;
    count_d      = count_q;
    addr_d       = addr_q;
    cmp_v_d      = cmp_v_q;
    cmp_idx_d    = cmp_idx_q;
    dst_d        = dst_q;
    sv_d         = sv_q;
    rv_d         = rv_q;
    found_d      = found_q;
    status_d     = status_q;
    we           = 1'b0;
    wa           = cmp_idx_q;
    wd           = {key_q, value_q};
    mv_d         = mv_q && !m_axis_tready_i;
    out_rv_d     = out_rv_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_total_d  = out_total_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d      = s_axis_tuser_i;
          key_d     = s_axis_tdata_i[KEY_BITS-1:0];
          value_d   = s_axis_tdata_i[FIELD_W+VAL_BITS-1:FIELD_W];
          rv_d      = '0;
          found_d   = 1'b0;
          status_d  = STAT_OK;
          addr_d    = '0;
          cmp_v_d   = 1'b0;
          if (s_axis_tuser_i == OP_CLEAR) begin
            if (count_q == '0) begin
              status_d = STAT_EMPTY;
            end else begin
              count_d = '0;
            end
            state_d = S_DONE;
          end else if ((s_axis_tuser_i == OP_REMOVE) && (count_q == '0)) begin
            status_d = STAT_EMPTY;
            state_d  = S_DONE;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          rv_d    = rd_q[VAL_BITS-1:0];
          found_d = 1'b1;
          cmp_v_d = 1'b0;
          case (op_q)
            OP_WRITE: begin
              we      = 1'b1;
              wa      = cmp_idx_q;
              wd      = {key_q, value_q};
              state_d = S_DONE;
            end
            OP_REMOVE: begin
              dst_d   = cmp_idx_q;
              addr_d  = CNT_W'(cmp_idx_q) + CNT_W'(1);
              sv_d    = 1'b0;
              state_d = S_SHIFT;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (addr_q < count_q) begin
          addr_d    = addr_q + CNT_W'(1);
          cmp_v_d   = 1'b1;
          cmp_idx_d = addr_q[IDX_W-1:0];
        end else begin
          cmp_v_d = 1'b0;
          case (op_q)
            OP_ACCESS, OP_WRITE: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                we      = 1'b1;
                wa      = count_q[IDX_W-1:0];
                wd      = {key_q, (op_q == OP_WRITE) ? value_q : {VAL_BITS{1'b0}}};
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              status_d = STAT_MISSING;
            end
            default: begin
            end
          endcase
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sv_q) begin
          we    = 1'b1;
          wa    = dst_q;
          wd    = rd_q;
          dst_d = dst_q + IDX_W'(1);
        end
        if (addr_q < count_q) begin
          addr_d = addr_q + CNT_W'(1);
          sv_d   = 1'b1;
        end else begin
          sv_d = 1'b0;
          if (!sv_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d         = 1'b1;
          out_rv_d     = rv_q;
          out_found_d  = found_q;
          out_status_d = status_q;
          out_total_d  = TOTAL_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      addr_q  <= '0;
      cmp_v_q <= 1'b0;
      sv_q    <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      cmp_v_q <= cmp_v_d;
      sv_q    <= sv_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    value_q      <= value_d;
    cmp_idx_q    <= cmp_idx_d;
    dst_q        <= dst_d;
    rv_q         <= rv_d;
    found_q      <= found_d;
    status_q     <= status_d;
    out_rv_q     <= out_rv_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_total_q  <= out_total_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[addr_q[IDX_W-1:0]];
  end

endmodule

// ----- src/oktv_checker.sv -----
// ----------------------------------------------------------------------------
// Ordered key-value table checker
// Port-level checks on result coding, stall behavior and request pacing.
// ----------------------------------------------------------------------------
module oktv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);
  import oktv_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tuser_o[2:1] == STAT_OK)
    else $error("found with non-ok status");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:1] != STAT_OK) |->
      (m_axis_tdata_o[31:0] == '0) && !m_axis_tuser_o[0])
    else $error("error result carries data");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("ready right after input transfer");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[39])
    else $error("result pad bit set");

endmodule

bind ordered_key_value_table_unit oktv_checker u_oktv_checker (.*);
